### src/kheap_pkg.sv
// Command, status and configuration register codes of the k-ary heap priority queue.
package kheap_pkg;

	localparam int CMD_W = 3;
	localparam int STAT_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd6;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_ORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRANCHING  = 2'd1;

endpackage

### src/kary_heap_priority_queue_core.sv
// K-ary min/max heap priority queue core: sequencer around one synchronous heap memory.
// A command's run time depends on its kind: a value search scans the store linearly, and each level of a
// sift either scans the children or divides for the parent index; build sifts every node. The single read
// port of the heap memory sets the pace.
// Throughput: one command at a time; start is taken the cycle after done.
// Reset clears count, configuration and control; heap memory contents are not reset.
// The receiver cannot stall: each result word shows for one cycle under done.
module kary_heap_priority_queue_core #(
	parameter int CAPACITY = 256,
	parameter int MAX_BRANCHING = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [kheap_pkg::CMD_W-1:0]          command,
	input  logic signed [VALUE_WIDTH-1:0]        value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kheap_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kheap_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 done,
	output logic [kheap_pkg::STAT_W-1:0]         status,
	output logic signed [VALUE_WIDTH-1:0]        data,
	output logic [$clog2(CAPACITY+1)-1:0]        position,
	output logic [$clog2(CAPACITY+1)-1:0]        count
);
	import kheap_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);      // counts and indexes
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KW = $clog2(MAX_BRANCHING + 1); // effective branching
	localparam int PW = CW + KW;                   // k*i+1
	localparam int DCW = $clog2(CW + 1);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_LOC_RD    = 5'd1;
	localparam logic [4:0] S_LOC_CMP   = 5'd2;
	localparam logic [4:0] S_LOC_MISS  = 5'd3;
	localparam logic [4:0] S_LOC_HIT   = 5'd4;
	localparam logic [4:0] S_SU_TEST   = 5'd5;
	localparam logic [4:0] S_DIV       = 5'd6;
	localparam logic [4:0] S_SU_RD     = 5'd7;
	localparam logic [4:0] S_SU_CMP    = 5'd8;
	localparam logic [4:0] S_RM_TEST   = 5'd9;
	localparam logic [4:0] S_FAV_RD    = 5'd10;
	localparam logic [4:0] S_FAV_CMP   = 5'd11;
	localparam logic [4:0] S_FAV_DONE  = 5'd12;
	localparam logic [4:0] S_LAST_RD   = 5'd13;
	localparam logic [4:0] S_LAST_GET  = 5'd14;
	localparam logic [4:0] S_BLD_NEXT  = 5'd15;
	localparam logic [4:0] S_SD_RD     = 5'd16;
	localparam logic [4:0] S_SD_LOAD   = 5'd17;
	localparam logic [4:0] S_SD_TEST   = 5'd18;
	localparam logic [4:0] S_ROOT_RD   = 5'd19;
	localparam logic [4:0] S_ROOT_GET  = 5'd20;
	localparam logic [4:0] S_DONE      = 5'd21;

	// configuration
	logic            order_q;
	logic [3:0]      branch_q;

	// control
	logic [4:0]      state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   i_q;      // current node / hole
	logic [CW-1:0]   b_q;      // build sweep position
	logic [CW-1:0]   n_q;      // divider dividend, then parent index
	logic [KW-1:0]   rem_q;
	logic [DCW-1:0]  dc_q;
	logic [KW-1:0]   k_q;
	logic [CW-1:0]   ch_q;     // child being scanned
	logic [KW-1:0]   jn_q;     // children scanned so far
	logic [CW-1:0]   best_q;
	logic            sd_q;     // child scan serves a sift-down of build

	// payload
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] cur_q;   // element travelling with the hole
	logic [VALUE_WIDTH-1:0] bval_q;
	logic [STAT_W-1:0]      status_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic [CW-1:0]          pos_q;

	// heap memory
	logic [VALUE_WIDTH-1:0] mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] rdata;
	logic                   mem_we;
	logic [CW-1:0]          mem_wa;
	logic [CW-1:0]          mem_ra;
	logic [VALUE_WIDTH-1:0] mem_wd;

	logic [4:0]      k_ext;
	logic [KW-1:0]   k_eff;
	logic [PW-1:0]   child_first;
	logic            has_child;
	logic [KW:0]     rem_sh;
	logic            rem_ge;

	function automatic logic better(input logic [VALUE_WIDTH-1:0] a,
	                                input logic [VALUE_WIDTH-1:0] b, input logic ord);
		better = ord ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	// clamp branching into 2..MAX_BRANCHING
	always_comb begin
		k_ext = {1'b0, branch_q};
		if (k_ext < 5'd2)
			k_ext = 5'd2;
		else if (k_ext > 5'(MAX_BRANCHING))
			k_ext = 5'(MAX_BRANCHING);
		k_eff = KW'(k_ext);
	end

	assign child_first = PW'(k_q) * PW'(i_q) + PW'(1);
	assign has_child = child_first < PW'(cnt_q);

	// one restoring divide step for the parent index (i-1)/k
	assign rem_sh = {rem_q, n_q[CW-1]};
	assign rem_ge = rem_sh >= {1'b0, k_q};

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_q;
		mem_wd = cur_q;
		mem_ra = i_q;
		unique case (state_q)
			S_LOC_MISS: begin
				mem_wa = cnt_q;
				mem_wd = val_q;
				mem_we = (cmd_q == CMD_APPEND) && (cnt_q != CW'(CAPACITY));
			end
			S_SU_TEST: mem_we = (i_q == '0);
			S_SU_RD: mem_ra = n_q;
			S_SU_CMP: begin
				mem_we = 1'b1;
				mem_wd = better(cur_q, rdata, order_q) ? rdata : cur_q;
			end
			S_FAV_RD: mem_ra = ch_q;
			S_FAV_DONE: begin
				mem_we = 1'b1;
				if (!sd_q || better(bval_q, cur_q, order_q))
					mem_wd = bval_q;
			end
			S_LAST_RD: mem_ra = cnt_q - CW'(1);
			S_SD_TEST: mem_we = !has_child;
			S_ROOT_RD: mem_ra = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa[AW-1:0]] <= mem_wd;
		rdata <= mem[mem_ra[AW-1:0]];
	end

	// configuration registers; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			branch_q <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_HEAP_ORDER)
				order_q <= cfg_data[0];
			else if (cfg_index == REG_BRANCHING)
				branch_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				val_q <= value;
				status_q <= STAT_OK;
				data_q <= '0;
				pos_q <= '0;
				k_q <= k_eff;
			end
			S_LOC_MISS: begin
				cur_q <= val_q;
				if (cmd_q == CMD_DELETE || cmd_q == CMD_FIND)
					status_q <= STAT_NOT_FOUND;
				else if (cnt_q == CW'(CAPACITY))
					status_q <= STAT_FULL;
			end
			S_LOC_HIT: begin
				if (cmd_q == CMD_FIND)
					pos_q <= i_q + CW'(1);
				else if (cmd_q == CMD_INSERT || cmd_q == CMD_APPEND)
					status_q <= STAT_DUPLICATE;
			end
			S_FAV_CMP: begin
				if (jn_q == '0 || better(rdata, bval_q, order_q))
					bval_q <= rdata;
			end
			S_LAST_GET: cur_q <= rdata;
			S_SD_LOAD: cur_q <= rdata;
			S_ROOT_RD: begin
				if (cnt_q == '0)
					status_q <= STAT_EMPTY;
			end
			S_ROOT_GET: data_q <= rdata;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_INSERT;
			cnt_q <= '0;
			i_q <= '0;
			b_q <= '0;
			n_q <= '0;
			rem_q <= '0;
			dc_q <= '0;
			ch_q <= '0;
			jn_q <= '0;
			best_q <= '0;
			sd_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						i_q <= '0;
						sd_q <= 1'b0;
						priority case (command)
							CMD_INSERT, CMD_APPEND, CMD_DELETE, CMD_FIND:
								state_q <= S_LOC_RD;
							CMD_BUILD: begin
								b_q <= cnt_q;
								sd_q <= 1'b1;
								state_q <= S_BLD_NEXT;
							end
							CMD_POP, CMD_PEEK: state_q <= S_ROOT_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				// linear search for the operand value
				S_LOC_RD: state_q <= (i_q < cnt_q) ? S_LOC_CMP : S_LOC_MISS;
				S_LOC_CMP: begin
					if (rdata == val_q) begin
						state_q <= S_LOC_HIT;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_LOC_RD;
					end
				end
				S_LOC_MISS: begin
					if (cmd_q == CMD_DELETE || cmd_q == CMD_FIND || cnt_q == CW'(CAPACITY)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						i_q <= cnt_q;
						state_q <= (cmd_q == CMD_INSERT) ? S_SU_TEST : S_DONE;
					end
				end
				S_LOC_HIT: state_q <= (cmd_q == CMD_DELETE) ? S_RM_TEST : S_DONE;
				// sift up: carry the hole toward the root
				S_SU_TEST: begin
					if (i_q == '0) begin
						state_q <= S_DONE;
					end else begin
						n_q <= i_q - CW'(1);
						rem_q <= '0;
						dc_q <= DCW'(CW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_ge ? KW'(rem_sh - {1'b0, k_q}) : rem_sh[KW-1:0];
					n_q <= {n_q[CW-2:0], rem_ge};
					dc_q <= dc_q - DCW'(1);
					if (dc_q == DCW'(1))
						state_q <= S_SU_RD;
				end
				S_SU_RD: state_q <= S_SU_CMP;
				S_SU_CMP: begin
					if (better(cur_q, rdata, order_q)) begin
						i_q <= n_q;
						state_q <= S_SU_TEST;
					end else begin
						state_q <= S_DONE;
					end
				end
				// removal: pull favored children up into the hole
				S_RM_TEST: begin
					if (has_child) begin
						ch_q <= CW'(child_first);
						jn_q <= '0;
						state_q <= S_FAV_RD;
					end else begin
						state_q <= S_LAST_RD;
					end
				end
				S_FAV_RD: state_q <= S_FAV_CMP;
				S_FAV_CMP: begin
					if (jn_q == '0 || better(rdata, bval_q, order_q))
						best_q <= ch_q;
					jn_q <= jn_q + KW'(1);
					ch_q <= ch_q + CW'(1);
					if (({1'b0, jn_q} + (KW+1)'(1) < {1'b0, k_q}) &&
					    (ch_q + CW'(1) < cnt_q))
						state_q <= S_FAV_RD;
					else
						state_q <= S_FAV_DONE;
				end
				S_FAV_DONE: begin
					if (!sd_q) begin
						i_q <= best_q;
						state_q <= S_RM_TEST;
					end else if (better(bval_q, cur_q, order_q)) begin
						i_q <= best_q;
						state_q <= S_SD_TEST;
					end else begin
						state_q <= S_BLD_NEXT;
					end
				end
				S_LAST_RD: state_q <= S_LAST_GET;
				S_LAST_GET: begin
					// drop the last slot; sift up unless the hole was that slot
					cnt_q <= cnt_q - CW'(1);
					state_q <= (i_q < cnt_q - CW'(1)) ? S_SU_TEST : S_DONE;
				end
				// build: sift down every node from the back
				S_BLD_NEXT: begin
					if (b_q == '0) begin
						state_q <= S_DONE;
					end else begin
						i_q <= b_q - CW'(1);
						b_q <= b_q - CW'(1);
						state_q <= S_SD_RD;
					end
				end
				S_SD_RD: state_q <= S_SD_LOAD;
				S_SD_LOAD: state_q <= S_SD_TEST;
				S_SD_TEST: begin
					if (has_child) begin
						ch_q <= CW'(child_first);
						jn_q <= '0;
						state_q <= S_FAV_RD;
					end else begin
						state_q <= S_BLD_NEXT;
					end
				end
				S_ROOT_RD: state_q <= (cnt_q == '0) ? S_DONE : S_ROOT_GET;
				S_ROOT_GET: begin
					i_q <= '0;
					state_q <= (cmd_q == CMD_POP) ? S_RM_TEST : S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = status_q;
	assign data = data_q;
	assign position = pos_q;
	assign count = cnt_q;

	// the element count never passes the store size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY)) else $error("element count above capacity");

	// a result word frees the block on the next cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

	// full is reported only with the store full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (count == CW'(CAPACITY)))
		else $error("full status with room left");

	// empty pop or peek carries zero data and zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (count == '0 && data == '0))
		else $error("empty status with elements or data");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the k-ary heap priority queue core: directed table, then random phases.
module tb_top;
	import kheap_pkg::*;

	localparam int CAP = 256;
	localparam int MAXK = 8;
	localparam int VW = 32;
	localparam int PW = $clog2(CAP + 1);
	// Watchdog: a full-store build with k = 2 is the slowest command by far.
	localparam int STALL_LIMIT = 400000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef logic signed [VW-1:0] word_t;

	typedef struct {
		logic [STAT_W-1:0] st;
		word_t             dat;
		logic [PW-1:0]     pos;
		logic [PW-1:0]     cnt;
	} outcome_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		word_t             val;
		bit                typed;
		logic [STAT_W-1:0] st;
		word_t             dat;
		logic [PW-1:0]     pos;
		logic [PW-1:0]     cnt;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [CMD_W-1:0] command;
	word_t value;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic [STAT_W-1:0] status;
	word_t data;
	logic [PW-1:0] position;
	logic [PW-1:0] count;

	kary_heap_priority_queue_core #(
		.CAPACITY(CAP),
		.MAX_BRANCHING(MAXK),
		.VALUE_WIDTH(VW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.data(data),
		.position(position),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow heap: our own copy of the store, the count and the registers
	// ------------------------------------------------------------------
	word_t heap_mirror [CAP];
	int unsigned held;
	bit max_order;
	logic [3:0] branch_raw;

	outcome_t pending_words[$];
	int mismatches;
	bit idle_enable;

	// effective k: the register value clamped to the supported range
	function automatic int unsigned fanout();
		if (branch_raw < 2) return 2;
		if (branch_raw > MAXK) return MAXK;
		return int'(branch_raw);
	endfunction

	// true when a belongs strictly above b for the current order
	function automatic bit ranks_above(word_t a, word_t b);
		return max_order ? (a > b) : (a < b);
	endfunction

	function automatic int find_slot(word_t v);
		for (int i = 0; i < held; i++)
			if (heap_mirror[i] == v) return i;
		return -1;
	endfunction

	function automatic int unsigned best_child(int unsigned i, int unsigned k);
		int unsigned first;
		int unsigned best;
		first = k * i + 1;
		best = first;
		for (int unsigned j = 1; j < k; j++) begin
			if (first + j >= held) break;
			if (ranks_above(heap_mirror[first + j], heap_mirror[best])) best = first + j;
		end
		return best;
	endfunction

	function automatic void bubble_up(int unsigned i, int unsigned k);
		int unsigned p;
		word_t t;
		while (i > 0 && i < held) begin
			p = (i - 1) / k;
			if (!ranks_above(heap_mirror[i], heap_mirror[p])) break;
			t = heap_mirror[i];
			heap_mirror[i] = heap_mirror[p];
			heap_mirror[p] = t;
			i = p;
		end
	endfunction

	function automatic void push_down(int unsigned i, int unsigned k);
		int unsigned c;
		word_t t;
		while (i < held && k * i + 1 < held) begin
			c = best_child(i, k);
			if (!ranks_above(heap_mirror[c], heap_mirror[i])) break;
			t = heap_mirror[i];
			heap_mirror[i] = heap_mirror[c];
			heap_mirror[c] = t;
			i = c;
		end
	endfunction

	// walk the hole down the favored children, plug it with the last element, sift that up
	function automatic void extract_at(int unsigned i, int unsigned k);
		int unsigned c;
		while (k * i + 1 < held) begin
			c = best_child(i, k);
			heap_mirror[i] = heap_mirror[c];
			i = c;
		end
		heap_mirror[i] = heap_mirror[held - 1];
		held--;
		bubble_up(i, k);
	endfunction

	// apply one command to the shadow heap and return the word it must produce
	function automatic outcome_t heap_apply(logic [CMD_W-1:0] cmd, word_t v);
		outcome_t r;
		int unsigned k;
		int at;
		k = fanout();
		r.st = STAT_OK;
		r.dat = '0;
		r.pos = '0;
		case (cmd)
			CMD_INSERT, CMD_APPEND: begin
				if (find_slot(v) >= 0) r.st = STAT_DUPLICATE;
				else if (held >= CAP) r.st = STAT_FULL;
				else begin
					heap_mirror[held] = v;
					held++;
					if (cmd == CMD_INSERT) bubble_up(held - 1, k);
				end
			end
			CMD_BUILD: begin
				for (int unsigned i = held; i > 0; i--) push_down(i - 1, k);
			end
			CMD_POP: begin
				if (held == 0) r.st = STAT_EMPTY;
				else begin
					r.dat = heap_mirror[0];
					extract_at(0, k);
				end
			end
			CMD_DELETE: begin
				at = find_slot(v);
				if (at < 0) r.st = STAT_NOT_FOUND;
				else extract_at(at, k);
			end
			CMD_FIND: begin
				at = find_slot(v);
				if (at < 0) r.st = STAT_NOT_FOUND;
				else r.pos = PW'(at + 1);
			end
			CMD_PEEK: begin
				if (held == 0) r.st = STAT_EMPTY;
				else r.dat = heap_mirror[0];
			end
			default: ;
		endcase
		r.cnt = PW'(held);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// hold start until the core takes the word; leave start high for a back-to-back word
	task automatic issue(logic [CMD_W-1:0] cmd, word_t v, bit typed, outcome_t want);
		outcome_t pred;
		command <= cmd;
		value <= v;
		start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pred = heap_apply(cmd, v);
		pending_words.push_back(typed ? want : pred);
	endtask

	task automatic pause_sender();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wd);
		cfg_index <= idx;
		cfg_data <= wd;
		cfg_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		cfg_valid <= 1'b0;
		if (idx == REG_HEAP_ORDER) max_order = wd[0];
		else if (idx == REG_BRANCHING) branch_raw = wd;
		@(posedge clk);
	endtask

	// drain outstanding words before touching the registers
	task automatic settle();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// operands: half the time a value already held so that finds and deletes hit
	function automatic word_t pick_operand();
		int r;
		r = $urandom_range(0, 9);
		if (held > 0 && r < 5) return heap_mirror[$urandom_range(0, held - 1)];
		if (r < 8) return $signed($urandom_range(0, 80)) - 40;
		return $urandom;
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 34) return CMD_INSERT;
		if (r < 40) return CMD_APPEND;
		if (r < 43) return CMD_BUILD;
		if (r < 58) return CMD_POP;
		if (r < 73) return CMD_DELETE;
		if (r < 88) return CMD_FIND;
		if (r < 97) return CMD_PEEK;
		return CMD_UNUSED;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: done marks one word, it cannot be held off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d data %0d position %0d count %0d",
						status, data, position, count);
			end else begin
				e = pending_words.pop_front();
				if (status !== e.st || data !== e.dat || position !== e.pos
						|| count !== e.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st %0d dat %0d pos %0d cnt %0d,",
							" got st %0d dat %0d pos %0d cnt %0d"},
							e.st, e.dat, e.pos, e.cnt, status, data, position, count);
				end
			end
		end
	end

	// Watchdog: count cycles in which no word moves on any port.
	int stall_cycles;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("** kary_heap_priority_queue_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// Directed rows run in the reset configuration: min-heap, k = 2.
	// Typed rows carry the word read straight off the behavior; the rest use the shadow heap.
	row_t directed [] = '{
		'{CMD_PEEK,   32'sd0,         1, STAT_EMPTY,     32'sd0,         9'd0, 9'd0},
		'{CMD_POP,    32'sd0,         1, STAT_EMPTY,     32'sd0,         9'd0, 9'd0},
		'{CMD_FIND,   32'sd7,         1, STAT_NOT_FOUND, 32'sd0,         9'd0, 9'd0},
		'{CMD_DELETE, 32'sd7,         1, STAT_NOT_FOUND, 32'sd0,         9'd0, 9'd0},
		'{CMD_BUILD,  32'sd0,         1, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_INSERT, 32'h7fffffff,   1, STAT_OK,        32'sd0,         9'd0, 9'd1},
		'{CMD_INSERT, 32'h80000000,   1, STAT_OK,        32'sd0,         9'd0, 9'd2},
		'{CMD_PEEK,   32'sd0,         1, STAT_OK,        32'h80000000,   9'd0, 9'd2},
		'{CMD_INSERT, 32'h7fffffff,   1, STAT_DUPLICATE, 32'sd0,         9'd0, 9'd2},
		'{CMD_APPEND, 32'h80000000,   1, STAT_DUPLICATE, 32'sd0,         9'd0, 9'd2},
		'{CMD_APPEND, 32'sd0,         1, STAT_OK,        32'sd0,         9'd0, 9'd3},
		'{CMD_FIND,   32'h80000000,   1, STAT_OK,        32'sd0,         9'd1, 9'd3},
		'{CMD_FIND,   32'sd0,         1, STAT_OK,        32'sd0,         9'd3, 9'd3},
		'{CMD_INSERT, -32'sd1,        0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_INSERT, 32'sd5,         0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_APPEND, -32'sd5,        0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_BUILD,  32'sd0,         0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_UNUSED, 32'h55555555,   1, STAT_OK,        32'sd0,         9'd0, 9'd6},
		'{CMD_DELETE, 32'sd0,         0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_DELETE, 32'sd12345,     1, STAT_NOT_FOUND, 32'sd0,         9'd0, 9'd5},
		'{CMD_POP,    32'sd0,         1, STAT_OK,        32'h80000000,   9'd0, 9'd4},
		'{CMD_FIND,   32'h80000000,   1, STAT_NOT_FOUND, 32'sd0,         9'd0, 9'd4},
		'{CMD_POP,    32'sd0,         0, STAT_OK,        32'sd0,         9'd0, 9'd0},
		'{CMD_PEEK,   32'sd0,         0, STAT_OK,        32'sd0,         9'd0, 9'd0}
	};

	// per-phase settings: order and raw branching, extremes and clamped values included
	bit         phase_order [10] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
	logic [3:0] phase_k     [10] = '{2, 3, 0, 15, 8, 1, 5, 4, 7, 6};

	initial begin
		outcome_t want;
		logic [CMD_W-1:0] c;
		held = 0;
		max_order = 0;
		branch_raw = 2;
		mismatches = 0;
		idle_enable = 1;
		start = 1'b0;
		command = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			want.st = directed[i].st;
			want.dat = directed[i].dat;
			want.pos = directed[i].pos;
			want.cnt = directed[i].cnt;
			issue(directed[i].cmd, directed[i].val, directed[i].typed, want);
			pause_sender();
		end

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			// toggle the unused data bits of the order register too
			reg_write(REG_HEAP_ORDER, {3'($urandom), phase_order[ph]});
			reg_write(REG_BRANCHING, phase_k[ph]);
			// no idling in the final phase
			idle_enable = (ph != 9);
			// reorder whatever is held under the new settings most of the time
			if ($urandom_range(0, 2) != 0) issue(CMD_BUILD, $urandom, 0, want);

			if (ph == 3) begin
				// fill the store, then knock on it while full, then drain most of it
				while (held < CAP) begin
					issue(CMD_INSERT, $urandom, 0, want);
					pause_sender();
				end
				issue(CMD_INSERT, $urandom, 0, want);
				issue(CMD_APPEND, $urandom, 0, want);
				issue(CMD_INSERT, heap_mirror[$urandom_range(0, CAP - 1)], 0, want);
				issue(CMD_APPEND, heap_mirror[$urandom_range(0, CAP - 1)], 0, want);
				issue(CMD_BUILD, 32'sd0, 0, want);
				issue(CMD_FIND, heap_mirror[CAP - 1], 0, want);
				for (int n = 0; n < 230; n++) begin
					issue($urandom_range(0, 4) == 0 ? CMD_DELETE : CMD_POP,
						pick_operand(), 0, want);
					pause_sender();
				end
			end else begin
				for (int n = 0; n < 76; n++) begin
					c = pick_command();
					issue(c, pick_operand(), 0, want);
					pause_sender();
				end
			end
		end

		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** kary_heap_priority_queue_core: PASSED **");
		else
			$display("** kary_heap_priority_queue_core: FAILED **");
		$finish;
	end

endmodule
